// File: rtl/core/mbm_pkg.sv
package mbm_pkg;

  // Command codes on the input channel
  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_DISK    = 3'd2;
  localparam logic [2:0] CMD_EXT     = 3'd3;
  localparam logic [2:0] CMD_ROM_ON  = 3'd4;
  localparam logic [2:0] CMD_ROM_OFF = 3'd5;

  // Target codes on the result channel
  localparam logic [2:0] TGT_MAIN  = 3'd0;
  localparam logic [2:0] TGT_ROM   = 3'd1;
  localparam logic [2:0] TGT_DISK0 = 3'd2;
  localparam logic [2:0] TGT_DISK1 = 3'd3;
  localparam logic [2:0] TGT_NONE  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_EXT_MODE = 1'b0;
  localparam logic CFG_ROM_SIZE = 1'b1;

  localparam int ROM_SIZE_W = 17;
  localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RST = 17'h08000;

  // Extended window bounds
  localparam logic [15:0] WIN_LO_A000 = 16'hA000;
  localparam logic [15:0] WIN_LO_8000 = 16'h8000;
  localparam logic [15:0] WIN_LO_0100 = 16'h0100;
  localparam logic [15:0] WIN_LO_0000 = 16'h0000;
  localparam logic [15:0] WIN_HI_DFFF = 16'hDFFF;
  localparam logic [15:0] WIN_HI_FFFF = 16'hFFFF;
  localparam logic [15:0] WIN_HI_7FFF = 16'h7FFF;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    K_READ,
    K_WRITE,
    K_DISK,
    K_EXT,
    K_ROM_ON,
    K_ROM_OFF,
    K_NOP
  } kind_t;

  // One classified item, as it waits between front and back
  typedef struct packed {
    kind_t       kind;
    logic [15:0] addr;
    logic        stack_op;
    logic [7:0]  value;
    logic        disk;
    logic [3:0]  mask;
    logic        redirect;
    logic [1:0]  win_page;
    logic [1:0]  stk_page;
    logic [2:0]  segment;
    logic [15:0] win_start;
    logic [15:0] win_end;
  } entry_t;

endpackage

// File: rtl/core/mbm_front.sv
module mbm_front (
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [2:0]      cmd,
  input  logic [15:0]     addr,
  input  logic            stack_op,
  input  logic [7:0]      port_value,
  input  logic            disk_select,
  input  logic            q_full,
  output logic            q_push,
  output mbm_pkg::entry_t q_entry
);

  mbm_pkg::kind_t kind;

  always_comb begin
    unique case (cmd)
      mbm_pkg::CMD_READ:    kind = mbm_pkg::K_READ;
      mbm_pkg::CMD_WRITE:   kind = mbm_pkg::K_WRITE;
      mbm_pkg::CMD_DISK:    kind = mbm_pkg::K_DISK;
      mbm_pkg::CMD_EXT:     kind = mbm_pkg::K_EXT;
      mbm_pkg::CMD_ROM_ON:  kind = mbm_pkg::K_ROM_ON;
      mbm_pkg::CMD_ROM_OFF: kind = mbm_pkg::K_ROM_OFF;
      default:              kind = mbm_pkg::K_NOP;
    endcase
  end

  always_comb begin
    q_entry          = '0;
    q_entry.kind     = kind;
    q_entry.addr     = addr;
    q_entry.stack_op = stack_op;
    q_entry.value    = port_value;
    q_entry.disk     = disk_select;
    // ram disk byte: mask bit0 = b6, bits 2:1 = b5, bit3 = b7
    q_entry.mask     = {port_value[7], port_value[5], port_value[5], port_value[6]};
    q_entry.redirect = port_value[4];
    q_entry.win_page = port_value[1:0];
    q_entry.stk_page = port_value[3:2];
    q_entry.segment  = port_value[5:3];
    if (port_value[2]) begin
      q_entry.win_start = mbm_pkg::WIN_LO_0000;
      q_entry.win_end   = mbm_pkg::WIN_HI_FFFF;
    end else begin
      unique case (port_value[1:0])
        2'd0: begin
          q_entry.win_start = mbm_pkg::WIN_LO_A000;
          q_entry.win_end   = mbm_pkg::WIN_HI_DFFF;
        end
        2'd1: begin
          q_entry.win_start = mbm_pkg::WIN_LO_8000;
          q_entry.win_end   = mbm_pkg::WIN_HI_DFFF;
        end
        2'd2: begin
          q_entry.win_start = mbm_pkg::WIN_LO_8000;
          q_entry.win_end   = mbm_pkg::WIN_HI_FFFF;
        end
        default: begin
          q_entry.win_start = mbm_pkg::WIN_LO_0100;
          q_entry.win_end   = mbm_pkg::WIN_HI_7FFF;
        end
      endcase
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

// File: rtl/core/mbm_queue.sv
module mbm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbm_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output mbm_pkg::entry_t head_entry
);

  mbm_pkg::entry_t             slot_r [mbm_pkg::QDEPTH];
  logic [mbm_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [mbm_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [mbm_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                        do_pop;

  assign full       = (count_r == mbm_pkg::QCNT_W'(mbm_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/core/mbm_back.sv
module mbm_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_index,
  input  logic [mbm_pkg::ROM_SIZE_W-1:0] cfg_data,
  input  logic                           q_valid,
  input  mbm_pkg::entry_t                q_entry,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     target,
  output logic [20:0]                    phys_addr,
  output logic [7:0]                     data_out,
  output logic                           video_notify
);

  logic                           ext_mode_r;
  logic [mbm_pkg::ROM_SIZE_W-1:0] rom_size_r;
  logic                           rom_on_r;
  logic [3:0]                     mask_r     [2];
  logic                           redirect_r [2];
  logic [1:0]                     wpage_r    [2];
  logic [1:0]                     spage_r    [2];
  logic [2:0]                     segment_r;
  logic [15:0]                    wstart_r;
  logic [15:0]                    wend_r;

  logic        out_valid_r;
  logic [2:0]  target_r, target_nxt;
  logic [20:0] phys_r, phys_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        video_r, video_nxt;

  logic        take;
  logic        is_access, is_write;
  logic [15:0] a;
  logic        win0, win1, ext_win;

  assign take      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = take;
  assign is_write  = (q_entry.kind == mbm_pkg::K_WRITE);
  assign is_access = is_write || (q_entry.kind == mbm_pkg::K_READ);
  assign a         = q_entry.addr;

  // upper half only; one mask bit per 8 KB window
  assign win0    = a[15] && mask_r[0][a[14:13]];
  assign win1    = a[15] && mask_r[1][a[14:13]];
  assign ext_win = mask_r[0][1] && (a >= wstart_r) && (a <= wend_r);

  always_comb begin
    target_nxt = mbm_pkg::TGT_NONE;
    phys_nxt   = '0;
    data_nxt   = '0;
    video_nxt  = 1'b0;
    if (is_access) begin
      priority if (ext_mode_r && redirect_r[0] && q_entry.stack_op) begin
        target_nxt = mbm_pkg::TGT_DISK0;
        phys_nxt   = {segment_r, spage_r[0], a};
      end else if (ext_mode_r && ext_win) begin
        target_nxt = mbm_pkg::TGT_DISK0;
        phys_nxt   = {segment_r, wpage_r[0], a};
      end else if (!ext_mode_r && redirect_r[0] && q_entry.stack_op) begin
        target_nxt = mbm_pkg::TGT_DISK0;
        phys_nxt   = {3'd0, spage_r[0], a};
      end else if (!ext_mode_r && redirect_r[1] && q_entry.stack_op) begin
        target_nxt = mbm_pkg::TGT_DISK1;
        phys_nxt   = {3'd0, spage_r[1], a};
      end else if (!ext_mode_r && win0) begin
        target_nxt = mbm_pkg::TGT_DISK0;
        phys_nxt   = {3'd0, wpage_r[0], a};
      end else if (!ext_mode_r && win1) begin
        target_nxt = mbm_pkg::TGT_DISK1;
        phys_nxt   = {3'd0, wpage_r[1], a};
      end else begin
        phys_nxt = {5'd0, a};
        if (!is_write && rom_on_r && ({1'b0, a} < rom_size_r)) begin
          target_nxt = mbm_pkg::TGT_ROM;
        end else begin
          target_nxt = mbm_pkg::TGT_MAIN;
        end
      end
      if (is_write) begin
        data_nxt  = q_entry.value;
        video_nxt = (target_nxt == mbm_pkg::TGT_MAIN) && a[15];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_mode_r <= 1'b0;
      rom_size_r <= mbm_pkg::ROM_SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mbm_pkg::CFG_EXT_MODE: ext_mode_r <= cfg_data[0];
        mbm_pkg::CFG_ROM_SIZE: rom_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_on_r      <= 1'b1;
      mask_r[0]     <= '0;
      mask_r[1]     <= '0;
      redirect_r[0] <= 1'b0;
      redirect_r[1] <= 1'b0;
      wpage_r[0]    <= '0;
      wpage_r[1]    <= '0;
      spage_r[0]    <= '0;
      spage_r[1]    <= '0;
      segment_r     <= '0;
      wstart_r      <= mbm_pkg::WIN_LO_A000;
      wend_r        <= mbm_pkg::WIN_HI_DFFF;
    end else if (take) begin
      unique case (q_entry.kind)
        mbm_pkg::K_DISK: begin
          mask_r[q_entry.disk]     <= q_entry.mask;
          redirect_r[q_entry.disk] <= q_entry.redirect;
          wpage_r[q_entry.disk]    <= q_entry.win_page;
          spage_r[q_entry.disk]    <= q_entry.stk_page;
        end
        mbm_pkg::K_EXT: begin
          segment_r <= q_entry.segment;
          wstart_r  <= q_entry.win_start;
          wend_r    <= q_entry.win_end;
        end
        mbm_pkg::K_ROM_ON:  rom_on_r <= 1'b1;
        mbm_pkg::K_ROM_OFF: rom_on_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      target_r <= target_nxt;
      phys_r   <= phys_nxt;
      data_r   <= data_nxt;
      video_r  <= video_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign target       = target_r;
  assign phys_addr    = phys_r;
  assign data_out     = data_r;
  assign video_notify = video_r;

  a_ctrl_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
    take && !is_access |=> target_r == mbm_pkg::TGT_NONE && phys_r == '0 && data_r == '0)
    else $error("control item did not yield an empty result");

  a_video_main_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && video_r |-> target_r == mbm_pkg::TGT_MAIN && phys_r[15])
    else $error("video flag on a non main RAM result");

  a_rom_off_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    take && q_entry.kind == mbm_pkg::K_ROM_OFF |=> !rom_on_r)
    else $error("ROM still enabled after disable");

  a_no_rom_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    take && !rom_on_r |=> target_r != mbm_pkg::TGT_ROM)
    else $error("ROM hit while ROM disabled");

endmodule

// File: rtl/core/memory_bank_mapper.sv
// Memory bank mapper: routes CPU accesses to main RAM, ROM or one of two
// paged RAM disks, and tracks the control bytes that set up the paging.
// Input stream: one item per transfer; tuser carries the command, stack flag
// and disk select, tdata the address and the control byte or write data.
// Every accepted item, access or not, gives exactly one result transfer;
// control items give target none with all other fields zero.
// Configuration writes (mode, ROM size) are taken at any cycle on cfg_*;
// cfg_ready is always high.
// Each item is held in the classifier queue, then in the routing stage's
// output register. Throughput: one item per cycle while the receiver is
// ready, limited by the single routing stage.
// Reset: queue empty, ROM enabled, paging cleared, window 0xA000-0xDFFF,
// dual disk mode and a 32 KB ROM.
// When the receiver stalls, the result is held in the output register and
// the four-entry queue keeps absorbing items; in_tready drops once it is
// full and rises again as soon as one entry drains.
module memory_bank_mapper (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,  // addr[15:0], port_value[23:16]
  input  logic [4:0]                     in_tuser,  // cmd[2:0], stack_op[3], disk_select[4]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata, // phys_addr[20:0], data_out[28:21], 0
  output logic [3:0]                     out_tuser, // target[2:0], video_notify[3]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [mbm_pkg::ROM_SIZE_W-1:0] cfg_data
);

  logic            q_full, q_push, q_pop, q_valid;
  mbm_pkg::entry_t push_entry, head_entry;
  logic [20:0]     phys_addr;
  logic [7:0]      data_out;
  logic [2:0]      target;
  logic            video_notify;

  mbm_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .cmd         (in_tuser[2:0]),
    .addr        (in_tdata[15:0]),
    .stack_op    (in_tuser[3]),
    .port_value  (in_tdata[23:16]),
    .disk_select (in_tuser[4]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  mbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  mbm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_entry      (head_entry),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .target       (target),
    .phys_addr    (phys_addr),
    .data_out     (data_out),
    .video_notify (video_notify)
  );

  assign cfg_ready = 1'b1;
  assign out_tdata = {3'd0, data_out, phys_addr};
  assign out_tuser = {video_notify, target};

endmodule

// File: tb/mbm_route_checker.sv
module mbm_route_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,  // addr[15:0], port_value[23:16]
  input  logic [4:0]  in_tuser,  // cmd[2:0], stack_op[3], disk_select[4]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata, // phys_addr[20:0], data_out[28:21], zero
  input  logic [3:0]  out_tuser, // target[2:0], video_notify[3]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  target;
    logic [20:0] phys;
    logic [7:0]  wdata;
    logic        video;
  } mapped_t;

  mapped_t expected_q[$];

  // shadow of the mapper's registers and paging state
  logic        ext_mode;
  logic [16:0] rom_limit;
  logic        rom_en;
  logic [3:0]  win_mask[2];
  logic        redirect[2];
  logic [1:0]  win_page[2];
  logic [1:0]  stk_page[2];
  logic [2:0]  segment;
  logic [15:0] win_lo;
  logic [15:0] win_hi;

  function automatic logic hits_window(logic d, logic [15:0] a);
    return win_mask[d] != 4'd0 && a[15] && win_mask[d][a[14:13]];
  endfunction

  function automatic mapped_t route(logic [15:0] a, logic stk, logic wr);
    mapped_t m;
    m = '0;
    m.target = mbm_pkg::TGT_MAIN;
    m.phys = {5'd0, a};
    if (ext_mode) begin
      if (redirect[0] && stk) begin
        m.target = mbm_pkg::TGT_DISK0;
        m.phys = {segment, stk_page[0], a};
      end else if (win_mask[0][1] && a >= win_lo && a <= win_hi) begin
        m.target = mbm_pkg::TGT_DISK0;
        m.phys = {segment, win_page[0], a};
      end
    end else begin
      if (redirect[0] && stk) begin
        m.target = mbm_pkg::TGT_DISK0;
        m.phys = {3'd0, stk_page[0], a};
      end else if (redirect[1] && stk) begin
        m.target = mbm_pkg::TGT_DISK1;
        m.phys = {3'd0, stk_page[1], a};
      end else if (hits_window(1'b0, a)) begin
        m.target = mbm_pkg::TGT_DISK0;
        m.phys = {3'd0, win_page[0], a};
      end else if (hits_window(1'b1, a)) begin
        m.target = mbm_pkg::TGT_DISK1;
        m.phys = {3'd0, win_page[1], a};
      end
    end
    // writes never land in ROM
    if (m.target == mbm_pkg::TGT_MAIN && !wr && rom_en && {1'b0, a} < rom_limit)
      m.target = mbm_pkg::TGT_ROM;
    return m;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    mapped_t     want;
    logic [2:0]  cmd;
    logic [15:0] a;
    logic [7:0]  v;
    logic        stk;
    logic        d;
    if (!rst_n) begin
      ext_mode = 1'b0;
      rom_limit = mbm_pkg::ROM_SIZE_RST;
      rom_en = 1'b1;
      for (int i = 0; i < 2; i++) begin
        win_mask[i] = '0;
        redirect[i] = 1'b0;
        win_page[i] = '0;
        stk_page[i] = '0;
      end
      segment = '0;
      win_lo = mbm_pkg::WIN_LO_A000;
      win_hi = mbm_pkg::WIN_HI_DFFF;
      expected_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mbm_pkg::CFG_EXT_MODE)
          ext_mode = cfg_data[0];
        else
          rom_limit = cfg_data;
      end
      // results first, so a transfer can never match an item taken at the same edge
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser 0x%0h",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("target", want.target, out_tuser[2:0]);
          check_field("phys_addr", want.phys, out_tdata[20:0]);
          check_field("data_out", want.wdata, out_tdata[28:21]);
          check_field("video_notify", want.video, out_tuser[3]);
          check_field("tdata padding", 0, out_tdata[31:29]);
        end
      end
      if (in_tvalid && in_tready) begin
        cmd = in_tuser[2:0];
        stk = in_tuser[3];
        d = in_tuser[4];
        a = in_tdata[15:0];
        v = in_tdata[23:16];
        want = '0;
        want.target = mbm_pkg::TGT_NONE;
        case (cmd)
          mbm_pkg::CMD_READ: want = route(a, stk, 1'b0);
          mbm_pkg::CMD_WRITE: begin
            want = route(a, stk, 1'b1);
            want.wdata = v;
            want.video = want.target == mbm_pkg::TGT_MAIN && a[15];
          end
          mbm_pkg::CMD_DISK: begin
            win_mask[d] = {v[7], v[5], v[5], v[6]};
            redirect[d] = v[4];
            win_page[d] = v[1:0];
            stk_page[d] = v[3:2];
          end
          mbm_pkg::CMD_EXT: begin
            if (v[2]) begin
              win_lo = mbm_pkg::WIN_LO_0000;
              win_hi = mbm_pkg::WIN_HI_FFFF;
            end else begin
              case (v[1:0])
                2'd0: begin
                  win_lo = mbm_pkg::WIN_LO_A000;
                  win_hi = mbm_pkg::WIN_HI_DFFF;
                end
                2'd1: begin
                  win_lo = mbm_pkg::WIN_LO_8000;
                  win_hi = mbm_pkg::WIN_HI_DFFF;
                end
                2'd2: begin
                  win_lo = mbm_pkg::WIN_LO_8000;
                  win_hi = mbm_pkg::WIN_HI_FFFF;
                end
                default: begin
                  win_lo = mbm_pkg::WIN_LO_0100;
                  win_hi = mbm_pkg::WIN_HI_7FFF;
                end
              endcase
            end
            segment = v[5:3];
          end
          mbm_pkg::CMD_ROM_ON: rom_en = 1'b1;
          mbm_pkg::CMD_ROM_OFF: rom_en = 1'b0;
          default: ;
        endcase
        expected_q.push_back(want);
      end
      pending <= expected_q.size();
    end
  end

endmodule

// File: tb/memory_bank_mapper_tb.sv
module memory_bank_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int PHASE_ITEMS = 185;
  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [4:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = mbm_pkg::CFG_EXT_MODE;
  logic [16:0] cfg_data = '0;

  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  logic [16:0] rom_bytes = mbm_pkg::ROM_SIZE_RST;

  memory_bank_mapper uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mbm_route_checker route_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= $urandom_range(99) >= stall_pct;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // valid stays high from one item to the next unless a gap is drawn
  task automatic issue(input logic [2:0] cmd, input logic [15:0] addr, input logic stk,
                       input logic [7:0] val, input logic disk);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {val, addr};
    in_tuser <= {disk, stk, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [15:0] pick_addr();
    logic [15:0] corner[12];
    corner = '{16'h0000, 16'h00FF, 16'h0100, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000,
               16'hDFFF, 16'hE000, 16'hFFFF, rom_bytes[15:0] - 16'd1, rom_bytes[15:0]};
    if ($urandom_range(3) == 0)
      return corner[$urandom_range(11)];
    return 16'($urandom);
  endfunction

  task automatic issue_random();
    logic [2:0] cmd;
    int         r;
    r = $urandom_range(99);
    if (r < 36)      cmd = mbm_pkg::CMD_READ;
    else if (r < 70) cmd = mbm_pkg::CMD_WRITE;
    else if (r < 82) cmd = mbm_pkg::CMD_DISK;
    else if (r < 90) cmd = mbm_pkg::CMD_EXT;
    else if (r < 93) cmd = mbm_pkg::CMD_ROM_ON;
    else if (r < 97) cmd = mbm_pkg::CMD_ROM_OFF;
    else             cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    issue(cmd, pick_addr(), $urandom_range(99) < 30, 8'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // both registers in consecutive transfers; mapper must be idle
  task automatic configure(input logic mode, input logic [16:0] rom);
    cfg_valid <= 1'b1;
    cfg_index <= mbm_pkg::CFG_EXT_MODE;
    cfg_data <= {16'($urandom), mode};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= mbm_pkg::CFG_ROM_SIZE;
    cfg_data <= rom;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rom_bytes = rom;
  endtask

  initial begin
    logic [16:0] rom_pick[8];
    int          idle_set[4];
    int          stall_set[4];
    int          ph;
    rom_pick = '{17'd32768, 17'd0, 17'd65536, 17'd0, 17'd0, 17'd65536, 17'd0, 17'd32768};
    idle_set = '{0, 64, 0, 38};
    stall_set = '{0, 0, 64, 38};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // dual disk scheme, reset settings
    issue(mbm_pkg::CMD_READ, 16'h0000, 1'b0, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_READ, 16'h8000, 1'b0, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_WRITE, 16'h0000, 1'b0, 8'hA5, 1'b0);
    issue(mbm_pkg::CMD_WRITE, 16'hFFFF, 1'b0, 8'hFF, 1'b0);
    issue(mbm_pkg::CMD_ROM_OFF, 16'h0000, 1'b0, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_READ, 16'h0000, 1'b0, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_ROM_ON, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
    issue(mbm_pkg::CMD_DISK, 16'h0000, 1'b0, 8'hFF, 1'b0);
    issue(mbm_pkg::CMD_READ, 16'h1234, 1'b1, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_WRITE, 16'hC000, 1'b0, 8'h3C, 1'b0);
    issue(mbm_pkg::CMD_DISK, 16'h0000, 1'b0, 8'h5E, 1'b1);
    issue(mbm_pkg::CMD_DISK, 16'h0000, 1'b0, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_READ, 16'h0100, 1'b1, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_READ, 16'h9FFF, 1'b0, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_EXT, 16'h0000, 1'b0, 8'h3F, 1'b0);
    issue(CMD_SPARE_LO, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
    issue(CMD_SPARE_HI, 16'h5555, 1'b0, 8'hAA, 1'b0);
    drain();

    // extended scheme, ROM covering the whole space
    configure(1'b1, 17'd65536);
    issue(mbm_pkg::CMD_EXT, 16'h0000, 1'b0, 8'h3C, 1'b0);
    issue(mbm_pkg::CMD_DISK, 16'h0000, 1'b0, 8'h20, 1'b0);
    issue(mbm_pkg::CMD_READ, 16'h0000, 1'b0, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_EXT, 16'h0000, 1'b0, 8'h03, 1'b0);
    issue(mbm_pkg::CMD_READ, 16'h00FF, 1'b0, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_READ, 16'h7FFF, 1'b0, 8'h00, 1'b0);
    issue(mbm_pkg::CMD_WRITE, 16'h8000, 1'b0, 8'h81, 1'b0);
    issue(mbm_pkg::CMD_READ, 16'hFFFF, 1'b1, 8'h00, 1'b0);
    drain();

    for (int i = 0; i < 8; i++) begin
      ph = (i / 2) % 4;
      configure(i[0], (i == 3 || i == 6) ? 17'($urandom_range(65536)) : rom_pick[i]);
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      repeat (PHASE_ITEMS) issue_random();
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: memory_bank_mapper.f
rtl/core/mbm_pkg.sv
rtl/core/mbm_front.sv
rtl/core/mbm_queue.sv
rtl/core/mbm_back.sv
rtl/core/memory_bank_mapper.sv
tb/mbm_route_checker.sv
tb/memory_bank_mapper_tb.sv
